// ----- sv/mbc_pkg.sv -----
// Shared constants, codes and control/status types of the modular binomial unit.
`timescale 1ns / 1ps

package mbc_pkg;

    // Field widths
    localparam int BASE_W  = 41;
    localparam int COUNT_W = 16;
    localparam int CNT_W   = COUNT_W - 1;   // magnitude of a non-negative count
    localparam int MOD_W   = 30;
    localparam int PROD_W  = 2 * MOD_W;     // full product of two residues
    localparam int RED_W   = MOD_W + 2;     // Barrett remainder, below 3p

    localparam longint MODULUS_INT = 64'd1000000007;
    localparam logic [MOD_W-1:0] MODULUS  = MOD_W'(MODULUS_INT);
    localparam logic [MOD_W-1:0] EXPONENT = MOD_W'(MODULUS_INT - 64'd2);

    // Barrett reciprocal: floor(2^(2k) / p), k = MOD_W
    localparam int MU_W = MOD_W + 1;
    localparam logic [MU_W-1:0] BARRETT_MU = MU_W'((64'd1 << PROD_W) / MODULUS_INT);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SM_WAIT,
        ST_LOOP_NUM,
        ST_LOOP_DEN,
        ST_LOOP_WAIT,
        ST_EXP_ACC,
        ST_EXP_SQ,
        ST_EXP_WAIT,
        ST_FINAL,
        ST_FIN_WAIT,
        ST_PUSH
    } t_state;

    // Operand pairs presented to the shared multiplier
    typedef enum logic [2:0] {
        OP_RAW_BASE,
        OP_NUM_FAC,
        OP_DEN_CNT,
        OP_ACC_SQ,
        OP_SQ_SQ,
        OP_NUM_ACC
    } t_opsel;

    // Write-back targets
    typedef enum logic [2:0] {
        DST_FAC,
        DST_NUM,
        DST_DEN,
        DST_ACC,
        DST_RES
    } t_dst;

    typedef struct packed {
        logic   load_in;
        logic   set_zero;
        logic   set_one;
        logic   init_loop;
        logic   advance;
        logic   init_exp;
        logic   bit_inc;
        logic   issue;
        t_opsel opsel;
        t_dst   dst;
        logic   push;
    } t_cmd;

    typedef struct packed {
        logic negative;
        logic zero_count;
        logic busy;
        logic loop_done;
        logic exp_bit;
        logic exp_last;
        logic out_free;
    } t_status;

endpackage

// ----- sv/mbc_channels.sv -----
// Valid/ready channel interfaces for input items and results.
`timescale 1ns / 1ps

interface mbc_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [mbc_pkg::BASE_W-1:0]   base_value;
    logic signed [mbc_pkg::COUNT_W-1:0]  term_count;

    modport source (output valid, output base_value, output term_count, input ready);
    modport sink   (input valid, input base_value, input term_count, output ready);
endinterface

interface mbc_out_if;
    logic                       valid;
    logic                       ready;
    logic [mbc_pkg::MOD_W-1:0]  coefficient;

    modport source (output valid, output coefficient, input ready);
    modport sink   (input valid, input coefficient, output ready);
endinterface

// ----- sv/modular_binomial_coefficient_unit.sv -----
// C(s+x, x) mod 1000000007 for signed base s and count x, one transaction at a time.
// Negative inputs and x = 0 skip the arithmetic; otherwise a setup step reduces s mod p,
// then x numerator/denominator steps and an exponentiation over 30 exponent bits follow.
// A new item waits until the last result is pushed, as all steps share the single mulmod pipeline.
// Reset: synchronous, active low; controller returns to idle, no result pending.
`timescale 1ns / 1ps

module modular_binomial_coefficient_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mbc_in_if.sink     i_item,
    mbc_out_if.source  o_result
);

    // Command and status buses between controller and datapath
    mbc_pkg::t_cmd    w_cmd;
    mbc_pkg::t_status w_status;

    // The controller owns the input handshake; a new transaction is taken only
    // in idle, while a finished result may still sit in the output register.
    mbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the operands, the loop counter, the exponent bit
    // index, the shared Barrett multiplier and the output register.
    mbc_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_base_value   (i_item.base_value),
        .i_term_count   (i_item.term_count),
        .o_out_valid    (o_result.valid),
        .i_out_ready    (o_result.ready),
        .o_coefficient  (o_result.coefficient)
    );

endmodule

// ----- sv/mbc_mulmod.sv -----
// Pipelined modular multiplier: product or raw value, Barrett-reduced mod p.
`timescale 1ns / 1ps

module mbc_mulmod (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_issue,
    input  logic                          i_use_raw,
    input  logic [mbc_pkg::MOD_W-1:0]     i_a,
    input  logic [mbc_pkg::MOD_W-1:0]     i_b,
    input  logic [mbc_pkg::PROD_W-1:0]    i_raw,
    input  mbc_pkg::t_dst                 i_dst,
    output logic                          o_valid,
    output mbc_pkg::t_dst                 o_dst,
    output logic [mbc_pkg::MOD_W-1:0]     o_value,
    output logic                          o_busy
);

    localparam int PW = mbc_pkg::PROD_W;
    localparam int MW = mbc_pkg::MU_W;
    localparam int RW = mbc_pkg::RED_W;
    localparam int Q2_W = PW + 2;
    localparam logic [RW-1:0] P1 = RW'(mbc_pkg::MODULUS);
    localparam logic [RW-1:0] P2 = P1 << 1;

    logic                 r_s1_v, r_s2_v, r_s3_v;
    mbc_pkg::t_dst        r_s1_dst, r_s2_dst, r_s3_dst;
    logic [PW-1:0]        r_s1_prod;
    logic [Q2_W-1:0]      r_s2_q2;
    logic [RW-1:0]        r_s2_lo, r_s3_lo, r_s3_qp;

    logic [PW-1:0]        n_s1_prod;
    logic [Q2_W-1:0]      n_s2_q2;
    logic [MW-1:0]        w_q3;
    logic [RW-1:0]        n_s3_qp;
    logic [RW-1:0]        w_r;

    always_comb begin
        n_s1_prod = i_use_raw ? i_raw : (PW'(i_a) * PW'(i_b));
        n_s2_q2   = Q2_W'(r_s1_prod[PW-1:mbc_pkg::MOD_W-1]) * Q2_W'(mbc_pkg::BARRETT_MU);
        w_q3      = r_s2_q2[Q2_W-1:mbc_pkg::MOD_W+1];
        n_s3_qp   = RW'(w_q3) * P1;   // only the low bits matter, remainder is below 3p
        w_r       = r_s3_lo - r_s3_qp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            r_s1_v <= i_issue;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_prod <= n_s1_prod;
        r_s1_dst  <= i_dst;
        r_s2_q2   <= n_s2_q2;
        r_s2_lo   <= r_s1_prod[RW-1:0];
        r_s2_dst  <= r_s1_dst;
        r_s3_qp   <= n_s3_qp;
        r_s3_lo   <= r_s2_lo;
        r_s3_dst  <= r_s2_dst;
    end

    always_comb begin
        priority if (w_r >= P2) begin
            o_value = mbc_pkg::MOD_W'(w_r - P2);
        end else if (w_r >= P1) begin
            o_value = mbc_pkg::MOD_W'(w_r - P1);
        end else begin
            o_value = mbc_pkg::MOD_W'(w_r);
        end
    end

    assign o_valid = r_s3_v;
    assign o_dst   = r_s3_dst;
    assign o_busy  = r_s1_v | r_s2_v | r_s3_v;

endmodule

// ----- sv/mbc_datapath.sv -----
// Datapath: operand registers, loop counters, shared multiplier and result register.
`timescale 1ns / 1ps

module mbc_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mbc_pkg::t_cmd                      i_cmd,
    output mbc_pkg::t_status                   o_status,
    input  logic signed [mbc_pkg::BASE_W-1:0]  i_base_value,
    input  logic signed [mbc_pkg::COUNT_W-1:0] i_term_count,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [mbc_pkg::MOD_W-1:0]          o_coefficient
);

    localparam int MW = mbc_pkg::MOD_W;
    localparam int CW = mbc_pkg::CNT_W;
    localparam int BW = mbc_pkg::BASE_W;
    localparam int EB_W = $clog2(MW);

    logic [BW-1:0]               r_base;
    logic [mbc_pkg::COUNT_W-1:0] r_count;
    logic [MW-1:0]               r_fac, r_num, r_den, r_acc, r_res;
    logic [CW-1:0]               r_cnt;
    logic [EB_W-1:0]             r_bit;
    logic                        r_out_valid;
    logic [MW-1:0]               r_out_coef;

    logic [MW-1:0]               w_a, w_b, w_wb_value, w_fac_inc;
    logic [mbc_pkg::PROD_W-1:0]  w_raw;
    logic                        w_wb_valid, w_busy;
    mbc_pkg::t_dst               w_wb_dst;

    // operand selection
    always_comb begin
        w_raw = mbc_pkg::PROD_W'(r_base[BW-2:0]);
        unique case (i_cmd.opsel)
            mbc_pkg::OP_RAW_BASE: begin w_a = '0;    w_b = '0;         end
            mbc_pkg::OP_NUM_FAC:  begin w_a = r_num; w_b = r_fac;      end
            mbc_pkg::OP_DEN_CNT:  begin w_a = r_den; w_b = MW'(r_cnt); end
            mbc_pkg::OP_ACC_SQ:   begin w_a = r_acc; w_b = r_den;      end
            mbc_pkg::OP_SQ_SQ:    begin w_a = r_den; w_b = r_den;      end
            mbc_pkg::OP_NUM_ACC:  begin w_a = r_num; w_b = r_acc;      end
            default:              begin w_a = '0;    w_b = '0;         end
        endcase
    end

    mbc_mulmod u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_issue   (i_cmd.issue),
        .i_use_raw (i_cmd.opsel == mbc_pkg::OP_RAW_BASE),
        .i_a       (w_a),
        .i_b       (w_b),
        .i_raw     (w_raw),
        .i_dst     (i_cmd.dst),
        .o_valid   (w_wb_valid),
        .o_dst     (w_wb_dst),
        .o_value   (w_wb_value),
        .o_busy    (w_busy)
    );

    // factor s+i, kept reduced by a wrap at p
    assign w_fac_inc = (r_fac == mbc_pkg::MODULUS - MW'(1)) ? '0 : r_fac + MW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_base  <= i_base_value;
            r_count <= i_term_count;
        end
        if (i_cmd.init_loop) begin
            r_num <= MW'(1);
            r_den <= MW'(1);
            r_cnt <= '0;
        end
        if (i_cmd.advance) begin
            r_fac <= w_fac_inc;
            r_cnt <= r_cnt + CW'(1);
        end
        if (i_cmd.init_exp) begin
            r_acc <= MW'(1);
            r_bit <= '0;
        end
        if (i_cmd.bit_inc) begin
            r_bit <= r_bit + EB_W'(1);
        end
        if (i_cmd.set_zero) begin
            r_res <= '0;
        end
        if (i_cmd.set_one) begin
            r_res <= MW'(1);
        end
        if (w_wb_valid) begin
            unique case (w_wb_dst)
                mbc_pkg::DST_FAC: r_fac <= w_wb_value;
                mbc_pkg::DST_NUM: r_num <= w_wb_value;
                mbc_pkg::DST_DEN: r_den <= w_wb_value;
                mbc_pkg::DST_ACC: r_acc <= w_wb_value;
                mbc_pkg::DST_RES: r_res <= w_wb_value;
                default:          r_res <= w_wb_value;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_coef <= r_res;
        end
    end

    always_comb begin
        o_status.negative   = r_base[BW-1] | r_count[mbc_pkg::COUNT_W-1];
        o_status.zero_count = (r_count == '0);
        o_status.busy       = w_busy;
        o_status.loop_done  = (r_cnt == r_count[CW-1:0]);
        o_status.exp_bit    = mbc_pkg::EXPONENT[r_bit];
        o_status.exp_last   = (r_bit == EB_W'(MW - 1));
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_coefficient = r_out_coef;

endmodule

// ----- sv/mbc_ctrl.sv -----
// Controller state machine sequencing the product loop, exponentiation and output.
`timescale 1ns / 1ps

module mbc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mbc_pkg::t_status  i_status,
    output mbc_pkg::t_cmd     o_cmd
);

    mbc_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mbc_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = mbc_pkg::ST_CHECK;
            end
            mbc_pkg::ST_CHECK: begin
                if (i_status.negative || i_status.zero_count) begin
                    n_state = mbc_pkg::ST_PUSH;
                end else begin
                    n_state = mbc_pkg::ST_SM_WAIT;
                end
            end
            mbc_pkg::ST_SM_WAIT: begin
                if (!i_status.busy) n_state = mbc_pkg::ST_LOOP_NUM;
            end
            mbc_pkg::ST_LOOP_NUM: n_state = mbc_pkg::ST_LOOP_DEN;
            mbc_pkg::ST_LOOP_DEN: n_state = mbc_pkg::ST_LOOP_WAIT;
            mbc_pkg::ST_LOOP_WAIT: begin
                if (!i_status.busy) begin
                    n_state = i_status.loop_done ? mbc_pkg::ST_EXP_ACC : mbc_pkg::ST_LOOP_NUM;
                end
            end
            mbc_pkg::ST_EXP_ACC: n_state = mbc_pkg::ST_EXP_SQ;
            mbc_pkg::ST_EXP_SQ:  n_state = mbc_pkg::ST_EXP_WAIT;
            mbc_pkg::ST_EXP_WAIT: begin
                if (!i_status.busy) begin
                    n_state = i_status.exp_last ? mbc_pkg::ST_FINAL : mbc_pkg::ST_EXP_ACC;
                end
            end
            mbc_pkg::ST_FINAL: n_state = mbc_pkg::ST_FIN_WAIT;
            mbc_pkg::ST_FIN_WAIT: begin
                if (!i_status.busy) n_state = mbc_pkg::ST_PUSH;
            end
            mbc_pkg::ST_PUSH: begin
                if (i_status.out_free) n_state = mbc_pkg::ST_IDLE;
            end
            default: n_state = mbc_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.load_in   = 1'b0;
        o_cmd.set_zero  = 1'b0;
        o_cmd.set_one   = 1'b0;
        o_cmd.init_loop = 1'b0;
        o_cmd.advance   = 1'b0;
        o_cmd.init_exp  = 1'b0;
        o_cmd.bit_inc   = 1'b0;
        o_cmd.issue     = 1'b0;
        o_cmd.opsel     = mbc_pkg::OP_RAW_BASE;
        o_cmd.dst       = mbc_pkg::DST_FAC;
        o_cmd.push      = 1'b0;
        unique case (r_state)
            mbc_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            mbc_pkg::ST_CHECK: begin
                priority if (i_status.negative) begin
                    o_cmd.set_zero = 1'b1;
                end else if (i_status.zero_count) begin
                    o_cmd.set_one = 1'b1;
                end else begin
                    // s mod p into the factor register, loop state to start
                    o_cmd.issue     = 1'b1;
                    o_cmd.opsel     = mbc_pkg::OP_RAW_BASE;
                    o_cmd.dst       = mbc_pkg::DST_FAC;
                    o_cmd.init_loop = 1'b1;
                end
            end
            mbc_pkg::ST_SM_WAIT: begin
                o_cmd.advance = !i_status.busy;
            end
            mbc_pkg::ST_LOOP_NUM: begin
                o_cmd.issue = 1'b1;
                o_cmd.opsel = mbc_pkg::OP_NUM_FAC;
                o_cmd.dst   = mbc_pkg::DST_NUM;
            end
            mbc_pkg::ST_LOOP_DEN: begin
                o_cmd.issue = 1'b1;
                o_cmd.opsel = mbc_pkg::OP_DEN_CNT;
                o_cmd.dst   = mbc_pkg::DST_DEN;
            end
            mbc_pkg::ST_LOOP_WAIT: begin
                o_cmd.advance  = !i_status.busy && !i_status.loop_done;
                o_cmd.init_exp = !i_status.busy && i_status.loop_done;
            end
            mbc_pkg::ST_EXP_ACC: begin
                o_cmd.issue = i_status.exp_bit;
                o_cmd.opsel = mbc_pkg::OP_ACC_SQ;
                o_cmd.dst   = mbc_pkg::DST_ACC;
            end
            mbc_pkg::ST_EXP_SQ: begin
                o_cmd.issue = 1'b1;
                o_cmd.opsel = mbc_pkg::OP_SQ_SQ;
                o_cmd.dst   = mbc_pkg::DST_DEN;
            end
            mbc_pkg::ST_EXP_WAIT: begin
                o_cmd.bit_inc = !i_status.busy && !i_status.exp_last;
            end
            mbc_pkg::ST_FINAL: begin
                o_cmd.issue = 1'b1;
                o_cmd.opsel = mbc_pkg::OP_NUM_ACC;
                o_cmd.dst   = mbc_pkg::DST_RES;
            end
            mbc_pkg::ST_FIN_WAIT: begin
            end
            mbc_pkg::ST_PUSH: begin
                o_cmd.push = i_status.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- bench/mbc_coef_checker.sv -----
// Scoreboard for the modular binomial unit: predicts each coefficient and compares results.
`timescale 1ns / 1ps

module mbc_coef_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    mbc_in_if    i_item,
    mbc_out_if   i_result,
    output int   o_mismatches,
    output int   o_outstanding
);

    localparam longint unsigned P = longint'(mbc_pkg::MODULUS_INT);

    logic [mbc_pkg::MOD_W-1:0] expected_coef[$];

    function automatic longint unsigned mulmod_p(longint unsigned a, longint unsigned b);
        return (a * b) % P;
    endfunction

    // C(s+x, x) mod p; numerator factors reduced mod p, x! inverted by Fermat
    function automatic logic [mbc_pkg::MOD_W-1:0] binomial_mod_p(
        logic signed [mbc_pkg::BASE_W-1:0]  s,
        logic signed [mbc_pkg::COUNT_W-1:0] x);
        longint unsigned s_res;
        longint unsigned num;
        longint unsigned den;
        longint unsigned acc;
        longint unsigned sq;
        longint unsigned e;
        int k;
        if (s < 0 || x < 0) begin
            return '0;
        end
        if (x == 0) begin
            return mbc_pkg::MOD_W'(1);
        end
        s_res = longint'(s) % P;
        num = 1;
        den = 1;
        for (k = 1; k <= int'(x); k++) begin
            num = mulmod_p(num, (s_res + longint'(k)) % P);
            den = mulmod_p(den, longint'(k));
        end
        acc = 1;
        sq = den;
        e = P - 2;
        while (e != 0) begin
            if (e[0]) begin
                acc = mulmod_p(acc, sq);
            end
            sq = mulmod_p(sq, sq);
            e = e >> 1;
        end
        return mbc_pkg::MOD_W'(mulmod_p(num, acc));
    endfunction

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    always @(posedge i_clk) begin
        logic [mbc_pkg::MOD_W-1:0] want;
        if (i_rst_n) begin
            if (i_item.valid && i_item.ready) begin
                expected_coef.insert(expected_coef.size(),
                                     binomial_mod_p(i_item.base_value, i_item.term_count));
            end
            if (i_result.valid && i_result.ready) begin
                if (expected_coef.size() == 0) begin
                    $error("coefficient: unexpected result %0d", i_result.coefficient);
                    o_mismatches <= o_mismatches + 1;
                end else begin
                    want = expected_coef.pop_front();
                    if (i_result.coefficient !== want) begin
                        $error("coefficient mismatch: expected %0d, actual %0d",
                               want, i_result.coefficient);
                        o_mismatches <= o_mismatches + 1;
                    end
                end
            end
            o_outstanding <= expected_coef.size();
        end
    end

endmodule

// ----- bench/tb.sv -----
// Top of the modular binomial testbench: clock, reset, stimulus, result backpressure, verdict.
`timescale 1ns / 1ps

module tb;

    // The limit is several times the slowest legitimate run (two full-size counts,
    // a handful of mid-size ones, the rest small).
    localparam int CYCLE_LIMIT  = 4_000_000;
    // Drain after the last result: longer than a short item's latency
    localparam int DRAIN_CYCLES = 600;
    localparam int N_RANDOM     = 100;

    localparam longint P_L      = longint'(mbc_pkg::MODULUS_INT);
    localparam longint BASE_MAX = (64'sd1 <<< (mbc_pkg::BASE_W - 1)) - 1;
    localparam longint BASE_MIN = -(64'sd1 <<< (mbc_pkg::BASE_W - 1));

    logic i_clk;
    logic i_rst_n;
    int   mismatches;
    int   outstanding;
    logic no_idle;      // shared by both sides: stretches with no gaps or stalls

    mbc_in_if  item_ch ();
    mbc_out_if result_ch ();

    modular_binomial_coefficient_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_result(result_ch)
    );

    mbc_coef_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_ch),
        .i_result     (result_ch),
        .o_mismatches (mismatches),
        .o_outstanding(outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Timeout watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    // Drive one transaction; entered and left at a falling edge.
    // valid is only dropped when a gap is drawn, so back-to-back items keep it high.
    task automatic send_item(input longint s, input int x);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            item_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_ch.valid      = 1'b1;
        item_ch.base_value = mbc_pkg::BASE_W'(s);
        item_ch.term_count = mbc_pkg::COUNT_W'(x);
        do @(posedge i_clk); while (!item_ch.ready);
        @(negedge i_clk);
    endtask

    // Sender holds off until the unit has returned every result
    task automatic hold_until_drained();
        item_ch.valid = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    // Random base: small, full 40-bit, or within a few of a multiple of p
    // (the last makes numerator factors hit zero mod p)
    function automatic longint random_base();
        longint v;
        case ($urandom_range(0, 2))
            0: v = longint'($urandom_range(0, 1000));
            1: v = (longint'($urandom_range(0, 255)) << 32) | longint'($urandom);
            default: begin
                v = longint'($urandom_range(0, 1099)) * P_L
                    + longint'($urandom_range(0, 80)) - 40;
                if (v < 0) v = -v;
            end
        endcase
        if (v > BASE_MAX) v = BASE_MAX;
        return v;
    endfunction

    // Receiver: a fresh stall is drawn per result
    initial begin
        int stall;
        result_ch.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                result_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            result_ch.ready = 1'b1;
            do @(posedge i_clk); while (!result_ch.valid);
            @(negedge i_clk);
        end
    end

    initial begin
        longint s;
        int     x;
        int     big_left;
        int     n;
        item_ch.valid      = 1'b0;
        item_ch.base_value = '0;
        item_ch.term_count = '0;
        no_idle            = 1'b0;
        i_rst_n            = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: field extremes and every special case
        send_item(0, 0);                    // zero count -> 1
        send_item(BASE_MAX, 0);             // zero count, largest base
        send_item(0, 1);
        send_item(5, 3);                    // C(8,3) = 56
        send_item(-1, 5);                   // negative base
        send_item(BASE_MIN, 0);             // negative base wins over zero count
        send_item(3, -1);                   // negative count
        send_item(3, -32768);
        send_item(BASE_MIN, -32768);
        send_item(P_L - 1, 1);              // only factor is p -> 0
        send_item(P_L - 3, 5);              // factor hits p mid-product
        send_item(P_L, 4);                  // base reduces to 0
        send_item(2 * P_L - 1, 2);
        send_item(P_L - 2, 1);              // largest residue as result
        send_item(BASE_MAX, 1);
        send_item(BASE_MAX, 100);
        send_item(12345, 1000);
        send_item(0, 32767);                // C(x, x) = 1 over the longest loop
        send_item(BASE_MAX, 32767);         // every magnitude bit of the count set, real product
        hold_until_drained();

        // Random: mostly valid sums, some negative fields, a few large counts
        big_left = 3;
        for (n = 0; n < N_RANDOM; n++) begin
            no_idle = ((n % 25) < 6);
            if ($urandom_range(0, 9) == 0) begin
                s = BASE_MIN + longint'($urandom_range(0, 255)) * (64'sd1 << 32)
                    + longint'($urandom);
            end else begin
                s = random_base();
            end
            if ($urandom_range(0, 11) == 0) begin
                x = -int'($urandom_range(1, 32768));
            end else if (big_left > 0 && $urandom_range(0, 29) == 0) begin
                x = $urandom_range(1000, 8191);
                big_left--;
            end else begin
                x = $urandom_range(0, 60);
            end
            send_item(s, x);
            if (n == N_RANDOM / 2) begin
                hold_until_drained();
            end
        end
        item_ch.valid = 1'b0;
        no_idle       = 1'b0;

        while (outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/mbc_pkg.sv
sv/mbc_channels.sv
sv/mbc_mulmod.sv
sv/mbc_datapath.sv
sv/mbc_ctrl.sv
sv/modular_binomial_coefficient_unit.sv
bench/mbc_coef_checker.sv
bench/tb.sv
